/* hdl/vbin_pkg.sv */
package vbin_pkg;

   localparam int BIN_ROWS   = 4;
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;

   localparam int CFG_W      = 13;
   localparam int CSR_ADDR_W = 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);
   localparam int PH_W       = (BIN_ROWS > 1) ? $clog2(BIN_ROWS) : 1;
   localparam int PIX_W      = 8;
   localparam int SUM_W      = PIX_W + $clog2(BIN_ROWS);
   localparam int IDX_W      = 22;
   localparam int LUMA_W     = 16;
   localparam int BIAS_W     = 17;
   localparam int REQ_W      = 24;
   localparam int RSP_W      = 32;
   localparam int PLANE_W    = 2;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd2064;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd1544;

   localparam int CY_R = 77;
   localparam int CY_G = 150;
   localparam int CY_B = 29;
   localparam int CU_R = 43;
   localparam int CU_G = 85;
   localparam int CU_B = 128;
   localparam int CV_R = 128;
   localparam int CV_G = 107;
   localparam int CV_B = 21;
   localparam int UV_BIAS    = 65536;
   localparam int CHROMA_OFS = 128;
   localparam int SAMPLE_MAX = 255;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   typedef enum logic [PLANE_W-1:0] {
      PLANE_Y = 2'd0,
      PLANE_U = 2'd1,
      PLANE_V = 2'd2
   } plane_type;

endpackage

/* hdl/vbin_line_ram.sv */
module vbin_line_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 30
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/vertical_bin_rgb_to_yuv420.sv */
// Vertical binning RGB to YUV 4:2:0 converter.
// The req_ channel takes one RGB8 pixel per transfer in raster order. Each column
// is averaged over groups of BIN_ROWS source rows in a line store. A pixel that
// closes a group yields one luma result; at even binned rows and even columns it
// yields luma, then U, then V on the rsp_ channel. rsp_tuser carries the plane
// and rsp_tlast marks the last luma sample of a frame.
// The csr_ port writes frame_width and frame_height; write them only while idle.
// A pixel's result passes the stage 1, stage 2 and stage 3 registers into the output register.
// Throughput: one pixel per clock while the result channel keeps up; a pixel that
// produces luma and chroma holds the output register for three transfers, and the
// single output register limits the sustained rate to one result per clock.
// The line store is one memory with a registered read; a result of the store
// write is forwarded to a read of the same column in the same cycle.
// Reset clears the column and row counters and empties the pipeline; the line
// store is not cleared. When rsp_tready is low the output register holds its
// result and the three stages ahead of it keep filling, so req_tready drops only
// once every stage is occupied.
module vertical_bin_rgb_to_yuv420
   import vbin_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // red, green, blue
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // plane_index, sample, zero fill
   output logic [PLANE_W-1:0]    rsp_tuser,   // plane
   output logic                  rsp_tlast,
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata
);

   typedef struct packed {
      logic             emit_y;
      logic             emit_uv;
      logic             frame_last;
      logic [IDX_W-1:0] y_idx;
      logic [IDX_W-1:0] uv_idx;
   } tag_type;

   typedef logic [2:0][SUM_W-1:0] sums_type;
   typedef logic [2:0][PIX_W-1:0] rgb_type;

   function automatic logic [PIX_W-1:0] chroma_clamp(input logic [BIAS_W-1:0] biased);
      logic [BIAS_W-9:0] q;
      logic [BIAS_W-9:0] s;
      q = biased[BIAS_W-1:8];
      s = q - (BIAS_W-8)'(CHROMA_OFS);
      if (q < (BIAS_W-8)'(CHROMA_OFS)) begin
         return '0;
      end else if (s > (BIAS_W-8)'(SAMPLE_MAX)) begin
         return PIX_W'(SAMPLE_MAX);
      end
      return s[PIX_W-1:0];
   endfunction

   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic [WID_W-1:0] eff_w;
   logic [HGT_W-1:0] eff_h;

   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [PH_W-1:0]  phase_ff;
   logic [ROW_W-1:0] brow_ff;

   logic             accept;
   logic             col_wrap;
   logic             row_wrap;
   logic             group_done;
   logic [HGT_W+1:0] grp_end;
   logic             in_range;
   logic             last_group;
   logic [IDX_W-1:0] y_base;
   logic [IDX_W-1:0] uv_base;

   logic             s1_vld_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_first_ff;
   logic             s1_wr_ff;
   logic             s1_emit_y_ff;
   logic             s1_emit_uv_ff;
   logic             s1_last_ff;
   logic [IDX_W-1:0] s1_ybase_ff;
   logic [IDX_W-1:0] s1_uvbase_ff;
   rgb_type          s1_px_ff;
   logic             s1_fwd_ff;
   sums_type         s1_fwd_sum_ff;

   sums_type         ram_rd_data;
   logic             ram_wr_en;
   sums_type         prev_sum;
   sums_type         sum_in;
   rgb_type          avg_in;

   logic             s2_vld_ff;
   tag_type          s2_tag_ff;
   rgb_type          s2_rgb_ff;
   tag_type          s2_tag_in;

   logic              s3_vld_ff;
   tag_type           s3_tag_ff;
   logic [LUMA_W-1:0] s3_y_ff;
   logic [BIAS_W-1:0] s3_u_ff;
   logic [BIAS_W-1:0] s3_cv_ff;
   logic [LUMA_W-1:0] s3_y_in;
   logic [BIAS_W-1:0] s3_u_in;
   logic [BIAS_W-1:0] s3_cv_in;

   logic             os_vld_ff;
   plane_type        os_plane_ff;
   logic             os_uv_ff;
   logic [PIX_W-1:0] os_sample_ff;
   logic [IDX_W-1:0] os_idx_ff;
   logic             os_last_ff;
   logic [PIX_W-1:0] os_u_ff;
   logic [PIX_W-1:0] os_cv_ff;
   logic [IDX_W-1:0] os_uvidx_ff;
   logic             os_final;

   logic s1_ready;
   logic s2_ready;
   logic s3_ready;
   logic os_ready;

   // Configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_addr))
            REG_FRAME_WIDTH:  width_ff  <= csr_wdata;
            REG_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = WID_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HGT_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = HGT_W'(MAX_HEIGHT);
      end else begin
         eff_h = HGT_W'(height_ff);
      end
   end

   // Position counters and per-pixel decisions
   assign accept     = req_tvalid && req_tready;
   assign col_wrap   = (WID_W'(col_ff) + WID_W'(1)) >= eff_w;
   assign row_wrap   = (HGT_W'(row_ff) + HGT_W'(1)) >= eff_h;
   assign group_done = phase_ff == PH_W'(BIN_ROWS - 1);
   assign grp_end    = (HGT_W+2)'(row_ff) - (HGT_W+2)'(phase_ff) + (HGT_W+2)'(BIN_ROWS);
   assign in_range   = grp_end <= (HGT_W+2)'(eff_h);
   assign last_group = in_range && ((grp_end + (HGT_W+2)'(BIN_ROWS)) > (HGT_W+2)'(eff_h));
   assign y_base     = IDX_W'(brow_ff) * IDX_W'(eff_w);
   assign uv_base    = IDX_W'(brow_ff >> 1) * IDX_W'(eff_w >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         phase_ff <= '0;
         brow_ff  <= '0;
      end else if (accept) begin
         if (col_wrap) begin
            col_ff <= '0;
            if (row_wrap) begin
               row_ff   <= '0;
               phase_ff <= '0;
               brow_ff  <= '0;
            end else begin
               row_ff <= row_ff + ROW_W'(1);
               if (group_done) begin
                  phase_ff <= '0;
                  brow_ff  <= brow_ff + ROW_W'(1);
               end else begin
                  phase_ff <= phase_ff + PH_W'(1);
               end
            end
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // Handshake between stages
   assign os_final   = (os_plane_ff == PLANE_V) || (os_plane_ff == PLANE_Y && !os_uv_ff);
   assign os_ready   = !os_vld_ff || (rsp_tready && os_final);
   assign s3_ready   = !s3_vld_ff || os_ready;
   assign s2_ready   = !s2_vld_ff || s3_ready;
   assign s1_ready   = !s1_vld_ff || s2_ready;
   assign req_tready = s1_ready;

   // Stage 1: line store read-modify-write
   assign ram_wr_en = s1_vld_ff && s2_ready && s1_wr_ff;

   vbin_line_ram #(
      .DEPTH (MAX_WIDTH),
      .WIDTH (3 * SUM_W)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (sum_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_vld_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff     <= col_ff;
         s1_first_ff   <= phase_ff == '0;
         s1_wr_ff      <= in_range;
         s1_emit_y_ff  <= in_range && group_done;
         s1_emit_uv_ff <= in_range && group_done && !brow_ff[0] && !col_ff[0];
         s1_last_ff    <= last_group && col_wrap;
         s1_ybase_ff   <= y_base;
         s1_uvbase_ff  <= uv_base;
         s1_px_ff      <= rgb_type'(req_tdata);
         s1_fwd_ff     <= ram_wr_en && (s1_col_ff == col_ff);
         s1_fwd_sum_ff <= sum_in;
      end
   end

   always_comb begin
      prev_sum = s1_fwd_ff ? s1_fwd_sum_ff : ram_rd_data;
      for (int c = 0; c < 3; c++) begin
         if (s1_first_ff) begin
            sum_in[c] = SUM_W'(s1_px_ff[c]);
         end else begin
            sum_in[c] = prev_sum[c] + SUM_W'(s1_px_ff[c]);
         end
         avg_in[c] = PIX_W'(sum_in[c] / BIN_ROWS);
      end
   end

   always_comb begin
      s2_tag_in.emit_y     = s1_emit_y_ff;
      s2_tag_in.emit_uv    = s1_emit_uv_ff;
      s2_tag_in.frame_last = s1_last_ff;
      s2_tag_in.y_idx      = s1_ybase_ff + IDX_W'(s1_col_ff);
      s2_tag_in.uv_idx     = s1_uvbase_ff + IDX_W'(s1_col_ff >> 1);
   end

   // Stage 2: binned pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_tag_ff <= s2_tag_in;
         s2_rgb_ff <= avg_in;
      end
   end

   // Stage 3: weighted sums, chroma biased to stay non-negative
   assign s3_y_in  = LUMA_W'(CY_R * s2_rgb_ff[0] + CY_G * s2_rgb_ff[1] + CY_B * s2_rgb_ff[2]);
   assign s3_u_in  = BIAS_W'(UV_BIAS + CU_B * s2_rgb_ff[2] - CU_R * s2_rgb_ff[0]
                             - CU_G * s2_rgb_ff[1]);
   assign s3_cv_in = BIAS_W'(UV_BIAS + CV_R * s2_rgb_ff[0] - CV_G * s2_rgb_ff[1]
                             - CV_B * s2_rgb_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_tag_ff <= s2_tag_ff;
         s3_y_ff   <= s3_y_in;
         s3_u_ff   <= s3_u_in;
         s3_cv_ff  <= s3_cv_in;
      end
   end

   // Output register: luma first, then U and V of the same pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         os_vld_ff <= 1'b0;
      end else if (os_ready) begin
         os_vld_ff <= s3_vld_ff && s3_tag_ff.emit_y;
      end
   end

   always_ff @(posedge clock) begin
      if (os_ready) begin
         os_plane_ff  <= PLANE_Y;
         os_uv_ff     <= s3_tag_ff.emit_uv;
         os_sample_ff <= s3_y_ff[LUMA_W-1:8];
         os_idx_ff    <= s3_tag_ff.y_idx;
         os_last_ff   <= s3_tag_ff.frame_last;
         os_u_ff      <= chroma_clamp(s3_u_ff);
         os_cv_ff     <= chroma_clamp(s3_cv_ff);
         os_uvidx_ff  <= s3_tag_ff.uv_idx;
      end else if (rsp_tready) begin
         case (os_plane_ff)
            PLANE_Y: begin
               os_plane_ff  <= PLANE_U;
               os_sample_ff <= os_u_ff;
               os_idx_ff    <= os_uvidx_ff;
               os_last_ff   <= 1'b0;
            end
            PLANE_U: begin
               os_plane_ff  <= PLANE_V;
               os_sample_ff <= os_cv_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = os_vld_ff;
   assign rsp_tdata  = {(RSP_W - IDX_W - PIX_W)'(0), os_sample_ff, os_idx_ff};
   assign rsp_tuser  = os_plane_ff;
   assign rsp_tlast  = os_last_ff;

endmodule

/* hdl/vbin_checker.sv */
module vbin_checker
   import vbin_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [RSP_W-1:0]   rsp_tdata,
   input logic [PLANE_W-1:0] rsp_tuser,
   input logic               rsp_tlast
);

   a_last_on_luma : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == PLANE_Y)
      else $error("frame end marked on a chroma result");

   a_v_follows_u : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == PLANE_U
      |=> rsp_tvalid && rsp_tuser == PLANE_V)
      else $error("U transfer not followed by V");

   a_uv_same_index : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser == PLANE_U
      |=> rsp_tdata[IDX_W-1:0] == $past(rsp_tdata[IDX_W-1:0]))
      else $error("U and V of one pixel carry different indexes");

   a_group_starts_luma : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tuser == PLANE_Y)
      else $error("result group does not start with luma");

   a_hold_stalled : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready
      |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

endmodule

bind vertical_bin_rgb_to_yuv420 vbin_checker u_vbin_checker (.*);
